// ===== rtl/core/lfu_pkg.sv =====
package lfu_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [CAP_BITS-1:0]   cap_type;

endpackage

// ===== rtl/core/lfu_cache_policy.sv =====
// channel | dir | handshake           | payload
// req     | in  | req_valid/req_stall | req_func, req_key, req_value
// rsp     | out | rsp_valid/rsp_stall | rsp_hit, rsp_read_value, rsp_evicted, rsp_evicted_key
// csr     | in  | csr_valid/csr_ready | csr_capacity
//
// A request, once taken, runs one pass over the entry memory for the match, the victim and
// a free slot, then one read-modify-write pass for ranks and counts, and is then posted.
// A get that misses and a put that changes nothing skip the second pass. After posting the
// block returns to idle and takes the next request. Each pass reads one entry per cycle.
// After reset a clearing pass over all entries runs first. A response held by rsp_stall
// does not block taking the next request, but holds back the posting of its response.
module lfu_cache_policy
   import lfu_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_func,
   input  key_type   req_key,
   input  value_type req_value,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output logic      rsp_hit,
   output value_type rsp_read_value,
   output logic      rsp_evicted,
   output key_type   rsp_evicted_key,
   input  logic      csr_valid,
   output logic      csr_ready,
   input  cap_type   csr_capacity
);

   localparam int IdxBits = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PtrBits = IdxBits + 1;
   localparam int OccBits = $clog2(ENTRIES + 1);
   localparam int CmpBits = (OccBits > CAP_BITS) ? OccBits : CAP_BITS;
   localparam logic [IdxBits-1:0] LastIdx = IdxBits'(ENTRIES - 1);

   typedef logic [IdxBits-1:0]    idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic      valid;
      key_type   key;
      value_type value;
      count_type count;
      idx_type   rank;
   } entry_type;

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_UPDATE, ST_DONE} state_type;
   typedef enum logic [1:0] {OP_NONE, OP_TOUCH, OP_INSERT} op_type;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [PtrBits-1:0] ptr_ff, ptr_in;
   logic [OccBits-1:0] occ_ff, occ_in;
   cap_type   capacity_ff, capacity_in;
   logic      rd_vld_ff, rd_vld_in;
   idx_type   rd_idx_ff, rd_idx_in;

   logic      func_ff, func_in;
   key_type   key_ff, key_in;
   value_type value_ff, value_in;

   logic      match_ff, match_in;
   idx_type   match_idx_ff, match_idx_in;
   idx_type   match_rank_ff, match_rank_in;
   value_type match_value_ff, match_value_in;
   logic      vic_ff, vic_in;
   idx_type   vic_idx_ff, vic_idx_in;
   idx_type   vic_rank_ff, vic_rank_in;
   count_type vic_cnt_ff, vic_cnt_in;
   key_type   vic_key_ff, vic_key_in;
   logic      free_ff, free_in;
   idx_type   free_idx_ff, free_idx_in;
   logic      evict_ff, evict_in;
   idx_type   ins_idx_ff, ins_idx_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_hit_ff, rsp_hit_in;
   value_type rsp_read_value_ff, rsp_read_value_in;
   logic      rsp_evicted_ff, rsp_evicted_in;
   key_type   rsp_evicted_key_ff, rsp_evicted_key_in;

   logic      mem_we, mem_re;
   idx_type   mem_waddr, mem_raddr;
   entry_type mem_wdata, upd;
   logic      issue, full, cap_zero;

   assign issue    = ptr_ff < PtrBits'(ENTRIES);
   assign cap_zero = capacity_ff == '0;
   assign full     = (CmpBits'(occ_ff) >= CmpBits'(capacity_ff)) ||
                     (occ_ff >= OccBits'(ENTRIES));

   // read-modify-write of one entry during the update pass
   always_comb begin
      upd = rd_data_ff;
      case (op_ff)
         OP_TOUCH: begin
            if (rd_idx_ff == match_idx_ff) begin
               upd.rank = '0;
               if (rd_data_ff.count != '1) begin
                  upd.count = rd_data_ff.count + 1'b1;
               end
               if (func_ff == FUNC_PUT) begin
                  upd.value = value_ff;
               end
            end else if (rd_data_ff.valid && rd_data_ff.rank < match_rank_ff) begin
               upd.rank = rd_data_ff.rank + 1'b1;
            end
         end
         OP_INSERT: begin
            if (rd_idx_ff == ins_idx_ff) begin
               upd.valid = 1'b1;
               upd.key   = key_ff;
               upd.value = value_ff;
               upd.count = COUNT_BITS'(1);
               upd.rank  = '0;
            end else if (evict_ff && rd_idx_ff == vic_idx_ff) begin
               upd.valid = 1'b0;
            end else if (rd_data_ff.valid &&
                         !(evict_ff && rd_data_ff.rank > vic_rank_ff)) begin
               upd.rank = rd_data_ff.rank + 1'b1;
            end
         end
         default: begin
            upd = rd_data_ff;
         end
      endcase
   end

   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      ptr_in             = ptr_ff;
      occ_in             = occ_ff;
      capacity_in        = capacity_ff;
      func_in            = func_ff;
      key_in             = key_ff;
      value_in           = value_ff;
      match_in           = match_ff;
      match_idx_in       = match_idx_ff;
      match_rank_in      = match_rank_ff;
      match_value_in     = match_value_ff;
      vic_in             = vic_ff;
      vic_idx_in         = vic_idx_ff;
      vic_rank_in        = vic_rank_ff;
      vic_cnt_in         = vic_cnt_ff;
      vic_key_in         = vic_key_ff;
      free_in            = free_ff;
      free_idx_in        = free_idx_ff;
      evict_in           = evict_ff;
      ins_idx_in         = ins_idx_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_hit_in         = rsp_hit_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_key_in = rsp_evicted_key_ff;
      mem_we             = 1'b0;
      mem_re             = 1'b0;
      mem_waddr          = rd_idx_ff;
      mem_raddr          = ptr_ff[IdxBits-1:0];
      mem_wdata          = upd;

      if (csr_valid) begin
         capacity_in = csr_capacity;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff[IdxBits-1:0];
            mem_wdata = '0;
            ptr_in    = ptr_ff + 1'b1;
            if (ptr_ff[IdxBits-1:0] == LastIdx) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               key_in   = req_key;
               value_in = req_value;
               match_in = 1'b0;
               vic_in   = 1'b0;
               free_in  = 1'b0;
               ptr_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               mem_re = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_data_ff.valid && rd_data_ff.key == key_ff && !match_ff) begin
                  match_in       = 1'b1;
                  match_idx_in   = rd_idx_ff;
                  match_rank_in  = rd_data_ff.rank;
                  match_value_in = rd_data_ff.value;
               end
               if (rd_data_ff.valid && (!vic_ff || rd_data_ff.count < vic_cnt_ff ||
                   (rd_data_ff.count == vic_cnt_ff && rd_data_ff.rank > vic_rank_ff))) begin
                  vic_in      = 1'b1;
                  vic_idx_in  = rd_idx_ff;
                  vic_rank_in = rd_data_ff.rank;
                  vic_cnt_in  = rd_data_ff.count;
                  vic_key_in  = rd_data_ff.key;
               end
               if (!rd_data_ff.valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == LastIdx) begin
                  ptr_in   = '0;
                  evict_in = 1'b0;
                  op_in    = OP_NONE;
                  if (func_ff == FUNC_GET) begin
                     if (match_in) begin
                        op_in = OP_TOUCH;
                     end
                  end else if (!cap_zero) begin
                     if (match_in) begin
                        op_in = OP_TOUCH;
                     end else if (full && vic_in) begin
                        op_in    = OP_INSERT;
                        evict_in = 1'b1;
                        if (free_in && free_idx_in < vic_idx_in) begin
                           ins_idx_in = free_idx_in;
                        end else begin
                           ins_idx_in = vic_idx_in;
                        end
                     end else if (free_in) begin
                        op_in      = OP_INSERT;
                        ins_idx_in = free_idx_in;
                     end
                  end
                  state_in = (op_in == OP_NONE) ? ST_DONE : ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (issue) begin
               mem_re = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               mem_we = 1'b1;
               if (rd_idx_ff == LastIdx) begin
                  ptr_in   = '0;
                  state_in = ST_DONE;
                  if (op_ff == OP_INSERT && !evict_ff) begin
                     occ_in = occ_ff + 1'b1;
                  end
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_hit_in         = match_ff;
               rsp_read_value_in  = (func_ff == FUNC_GET && match_ff) ? match_value_ff : '0;
               rsp_evicted_in     = evict_ff;
               rsp_evicted_key_in = evict_ff ? vic_key_ff : '0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_vld_in = mem_re;
      rd_idx_in = mem_raddr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         op_ff        <= OP_NONE;
         ptr_ff       <= '0;
         occ_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         rd_vld_ff    <= 1'b0;
         match_ff     <= 1'b0;
         vic_ff       <= 1'b0;
         free_ff      <= 1'b0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         ptr_ff       <= ptr_in;
         occ_ff       <= occ_in;
         capacity_ff  <= capacity_in;
         rd_vld_ff    <= rd_vld_in;
         match_ff     <= match_in;
         vic_ff       <= vic_in;
         free_ff      <= free_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff          <= rd_idx_in;
      func_ff            <= func_in;
      key_ff             <= key_in;
      value_ff           <= value_in;
      match_idx_ff       <= match_idx_in;
      match_rank_ff      <= match_rank_in;
      match_value_ff     <= match_value_in;
      vic_idx_ff         <= vic_idx_in;
      vic_rank_ff        <= vic_rank_in;
      vic_cnt_ff         <= vic_cnt_in;
      vic_key_ff         <= vic_key_in;
      free_idx_ff        <= free_idx_in;
      ins_idx_ff         <= ins_idx_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_key_ff <= rsp_evicted_key_in;
   end

   assign req_stall       = state_ff != ST_IDLE;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evicted_key_ff;

endmodule

// ===== rtl/core/lfu_checker.sv =====
module lfu_checker
   import lfu_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_stall,
   input logic      rsp_valid,
   input logic      rsp_stall,
   input logic      rsp_hit,
   input value_type rsp_read_value,
   input logic      rsp_evicted,
   input key_type   rsp_evicted_key
);

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_evicted_key) && $stable(rsp_hit))
      else $error("response dropped or changed under stall");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // clearing pass after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("request taken during clearing pass");

   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit && rsp_read_value == '0)
      else $error("eviction reported on a hit or with read data");

   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_evicted || rsp_evicted_key == '0) &&
                    (rsp_hit || rsp_read_value == '0))
      else $error("unused response field not zero");

endmodule

bind lfu_cache_policy lfu_checker u_lfu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_read_value  (rsp_read_value),
   .rsp_evicted     (rsp_evicted),
   .rsp_evicted_key (rsp_evicted_key)
);

// ===== tb/sv/tb_lfu_cache_policy.sv =====
module tb_lfu_cache_policy;
   import lfu_pkg::*;

   localparam int SLOTS    = 16;
   localparam int CNT_BITS = 16;
   localparam int CNT_MAX  = (1 << CNT_BITS) - 1;
   localparam int POOL     = 24;

   typedef struct packed {
      logic      func;
      key_type   key;
      value_type value;
   } cache_req_t;

   typedef struct packed {
      logic      hit;
      value_type read_value;
      logic      evicted;
      key_type   evicted_key;
   } cache_rsp_t;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   logic      req_func = FUNC_GET;
   key_type   req_key = '0;
   value_type req_value = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic      rsp_hit;
   value_type rsp_read_value;
   logic      rsp_evicted;
   key_type   rsp_evicted_key;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   cap_type   csr_capacity = CAP_RESET;

   lfu_cache_policy #(.ENTRIES(SLOTS), .COUNT_BITS(CNT_BITS)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the store
   logic        slot_valid [SLOTS] = '{default: 1'b0};
   key_type     slot_key   [SLOTS];
   value_type   slot_value [SLOTS];
   int unsigned slot_count [SLOTS];
   int unsigned slot_rank  [SLOTS];
   int unsigned fill = 0;
   int unsigned cap_limit = CAP_RESET;

   cache_req_t request_queue [$];
   cache_rsp_t predicted_replies [$];
   key_type    key_pool [POOL];

   int  failures = 0;
   int  queued_total = 0;
   int  checked_total = 0;
   bit  idle_on = 1'b1;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   function automatic void touch_slot(int idx);
      int unsigned r;
      r = slot_rank[idx];
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_rank[i] < r)
            slot_rank[i]++;
      slot_rank[idx] = 0;
      if (slot_count[idx] < CNT_MAX)
         slot_count[idx]++;
   endfunction

   function automatic cache_rsp_t cache_access(logic func, key_type key, value_type value);
      cache_rsp_t  res;
      int          match;
      int          victim;
      int          free_slot;
      int unsigned eff_cap;
      res = '0;
      match = -1;
      victim = -1;
      free_slot = -1;
      eff_cap = (cap_limit < SLOTS) ? cap_limit : SLOTS;
      for (int i = 0; i < SLOTS; i++)
         if (match < 0 && slot_valid[i] && slot_key[i] == key)
            match = i;
      res.hit = (match >= 0);
      if (func == FUNC_GET) begin
         if (match >= 0) begin
            res.read_value = slot_value[match];
            touch_slot(match);
         end
      end else if (eff_cap != 0) begin
         if (match >= 0) begin
            slot_value[match] = value;
            touch_slot(match);
         end else begin
            if (fill >= eff_cap) begin
               for (int i = 0; i < SLOTS; i++)
                  if (slot_valid[i] && (victim < 0 || slot_count[i] < slot_count[victim] ||
                      (slot_count[i] == slot_count[victim] &&
                       slot_rank[i] > slot_rank[victim])))
                     victim = i;
               if (victim >= 0) begin
                  res.evicted = 1'b1;
                  res.evicted_key = slot_key[victim];
                  slot_valid[victim] = 1'b0;
                  for (int i = 0; i < SLOTS; i++)
                     if (slot_valid[i] && slot_rank[i] > slot_rank[victim])
                        slot_rank[i]--;
                  if (fill > 0)
                     fill--;
               end
            end
            for (int i = 0; i < SLOTS; i++)
               if (free_slot < 0 && !slot_valid[i])
                  free_slot = i;
            if (free_slot >= 0) begin
               for (int i = 0; i < SLOTS; i++)
                  if (slot_valid[i])
                     slot_rank[i]++;
               slot_valid[free_slot] = 1'b1;
               slot_key[free_slot] = key;
               slot_value[free_slot] = value;
               slot_count[free_slot] = 1;
               slot_rank[free_slot] = 0;
               fill++;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : driver
      cache_req_t nxt;
      if (!reset) begin
         if (req_valid && !req_stall)
            predicted_replies.push_back(cache_access(req_func, req_key, req_value));
         if (!req_valid || !req_stall) begin
            if (send_gap == 0 && idle_on && request_queue.size() > 0 &&
                $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 17);
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
               nxt = request_queue.pop_front();
               req_valid <= 1'b1;
               req_func  <= nxt.func;
               req_key   <= nxt.key;
               req_value <= nxt.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      cache_rsp_t exp_rsp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            checked_total++;
            if (predicted_replies.size() == 0) begin
               $error("unexpected response: hit %0d key %h", rsp_hit, rsp_evicted_key);
               failures++;
            end else begin
               exp_rsp = predicted_replies.pop_front();
               if (rsp_hit !== exp_rsp.hit) begin
                  $error("hit: expected %0d, actual %0d", exp_rsp.hit, rsp_hit);
                  failures++;
               end
               if (rsp_read_value !== exp_rsp.read_value) begin
                  $error("read_value: expected %h, actual %h",
                         exp_rsp.read_value, rsp_read_value);
                  failures++;
               end
               if (rsp_evicted !== exp_rsp.evicted) begin
                  $error("evicted: expected %0d, actual %0d", exp_rsp.evicted, rsp_evicted);
                  failures++;
               end
               if (rsp_evicted_key !== exp_rsp.evicted_key) begin
                  $error("evicted_key: expected %h, actual %h",
                         exp_rsp.evicted_key, rsp_evicted_key);
                  failures++;
               end
            end
         end
         // one long back-pressure stretch so the request side fills up
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && checked_total >= 60) begin
            hold_done = 1'b1;
            hold_left = 600;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_req(logic func, key_type key, value_type value);
      request_queue.push_back({func, key, value});
      queued_total++;
   endtask

   task automatic drain();
      while (checked_total != queued_total)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_capacity(cap_type c);
      drain();
      @(posedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= c;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      cap_limit = c;
   endtask

   task automatic random_phase(cap_type c, int n, bit idle);
      key_type k;
      int      pick;
      set_capacity(c);
      idle_on = idle;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            k = key_pool[$urandom_range(0, 5)];
         else if (pick < 85)
            k = key_pool[$urandom_range(0, POOL - 1)];
         else if (pick < 90)
            k = (pick & 1) ? '1 : '0;
         else
            k = $urandom;
         push_req(logic'($urandom_range(0, 1)), k, $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < POOL; i++)
         key_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty store, key extremes, update in place
      push_req(FUNC_GET, '0, 32'h0);
      push_req(FUNC_PUT, '0, '1);
      push_req(FUNC_GET, '0, 32'h0);
      push_req(FUNC_PUT, '1, '0);
      push_req(FUNC_PUT, '1, 32'h1234_5678);
      push_req(FUNC_GET, '1, '1);
      push_req(FUNC_GET, '0, 32'h0);
      for (int i = 0; i < 8; i++)
         push_req(FUNC_PUT, key_pool[i], $urandom);

      // capacity below occupancy: evict, tie goes to least recent
      set_capacity(3);
      push_req(FUNC_PUT, 32'h5A5A_5A5A, 32'h1);
      push_req(FUNC_GET, key_pool[7], 32'h0);
      push_req(FUNC_PUT, 32'hA5A5_A5A5, 32'h2);
      push_req(FUNC_PUT, key_pool[0], 32'h3);

      // zero capacity: puts ignored, gets still served
      set_capacity(0);
      push_req(FUNC_PUT, '0, 32'h1);
      push_req(FUNC_PUT, 32'hDEAD_BEEF, 32'h2);
      push_req(FUNC_GET, '0, 32'h0);

      random_phase(31, 200, 1'b1);
      random_phase(1, 40, 1'b1);
      random_phase(0, 20, 1'b1);
      random_phase(cap_type'($urandom_range(2, 15)), 60, 1'b1);
      random_phase(16, 80, 1'b1);
      random_phase(5, 100, 1'b0);

      drain();
      if (failures == 0 && predicted_replies.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
